FILE: rtl/core/skvf_pkg.sv
// ----------------------------------------------------------------------------
// skvf_pkg: shared definitions for the scalar Kalman velocity filter
// Fixed-point widths, register indexes, reset values and the lane control
// bundle used by the sequencer and the per-axis lanes.
// ----------------------------------------------------------------------------
package skvf_pkg;

  localparam int DATA_W     = 32;           // Q16.16 value width
  localparam int FRAC_W     = 16;           // fractional bits
  localparam int GAIN_W     = FRAC_W + 1;   // gain is 0 .. 1.0 in Q1.16
  localparam int CFG_ADDR_W = 2;
  localparam int AXES_DEF   = 3;

  // Number of divider iterations: one quotient bit per cycle.
  localparam int DIV_STEPS  = GAIN_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  localparam logic [CFG_ADDR_W-1:0] REG_MEAS_NOISE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PROC_NOISE = 2'd1;

  localparam logic [DATA_W-1:0] MEAS_NOISE_RESET = 32'd131072000;  // 2000.0
  localparam logic [DATA_W-1:0] PROC_NOISE_RESET = 32'd65536;      // 1.0

  // Step strobes broadcast from the sequencer to every lane.
  typedef struct packed {
    logic load;   // latch sample, start division
    logic step;   // one restoring division step
    logic mul;    // form gain products
    logic upd;    // write back estimate and variance
  } lane_ctrl_t;

endpackage

FILE: rtl/core/skvf_lane.sv
// ----------------------------------------------------------------------------
// skvf_lane: one axis of the scalar Kalman filter
// Holds the axis state, computes the gain with a bit-serial divider and
// applies the estimate and variance updates.
// ----------------------------------------------------------------------------
module skvf_lane (
  input  logic                       clk,
  input  logic                       rst_n,
  input  skvf_pkg::lane_ctrl_t       ctrl,
  input  logic [skvf_pkg::DATA_W-1:0] sample,
  input  logic [skvf_pkg::DATA_W-1:0] meas_noise,
  input  logic [skvf_pkg::DATA_W-1:0] proc_noise,
  output logic [skvf_pkg::DATA_W-1:0] estimate
);
  import skvf_pkg::*;

  // Axis state, cleared by reset.
  logic [DATA_W-1:0]   prior_r,  prior_nxt;
  logic [DATA_W-1:0]   var_r,    var_nxt;

  // Working registers.
  logic [DATA_W:0]     den_r;        // P + R, exact
  logic [DATA_W:0]     rem_r;        // partial remainder, below den whenever den is nonzero
  logic [GAIN_W-1:0]   nq_r;         // numerator bits out, quotient bits in
  logic                zero_den_r;
  logic [DATA_W:0]     innov_r;      // sample - prior, signed
  logic [GAIN_W+DATA_W:0]   corr_prod_r;  // signed gain * innovation
  logic [GAIN_W+DATA_W-1:0] kp_prod_r;    // gain * P

  logic [DATA_W+1:0]   rem_sh;
  logic                q_bit;
  logic [GAIN_W-1:0]   gain;
  logic [DATA_W+2:0]   corr;
  logic [DATA_W+3:0]   est_sum;
  logic [DATA_W:0]     var_sum;

  always_comb begin
    rem_sh = {rem_r, nq_r[GAIN_W-1]};
    q_bit  = (rem_sh >= {1'b0, den_r});
  end

  assign gain = zero_den_r ? '0 : nq_r;

  // Floor of the product over 2^16 is an arithmetic shift.
  assign corr    = {corr_prod_r[GAIN_W+DATA_W], corr_prod_r[GAIN_W+DATA_W:FRAC_W]};
  assign est_sum = {{4{prior_r[DATA_W-1]}}, prior_r} + {corr[DATA_W+2], corr};
  // kp never exceeds P, so this subtraction cannot go negative.
  assign var_sum = {1'b0, var_r} + {1'b0, proc_noise}
                 - {1'b0, kp_prod_r[FRAC_W +: DATA_W]};

  always_comb begin
    prior_nxt = prior_r;
    var_nxt   = var_r;
    if (ctrl.upd) begin
      if (est_sum[DATA_W+3:DATA_W-1] == '0 || est_sum[DATA_W+3:DATA_W-1] == '1) begin
        prior_nxt = est_sum[DATA_W-1:0];
      end else if (est_sum[DATA_W+3]) begin
        prior_nxt = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        prior_nxt = {1'b0, {(DATA_W-1){1'b1}}};
      end
      var_nxt = var_sum[DATA_W] ? '1 : var_sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_r <= '0;
      var_r   <= '0;
    end else begin
      prior_r <= prior_nxt;
      var_r   <= var_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      den_r      <= {1'b0, var_r} + {1'b0, meas_noise};
      zero_den_r <= (var_r == '0) && (meas_noise == '0);
      // Numerator is P * 2^16; its top bits (P >> 1) are already below den.
      rem_r      <= {2'b00, var_r[DATA_W-1:1]};
      nq_r       <= {var_r[0], {FRAC_W{1'b0}}};
      innov_r    <= {sample[DATA_W-1], sample} - {prior_r[DATA_W-1], prior_r};
    end else if (ctrl.step) begin
      rem_r <= q_bit ? rem_sh[DATA_W:0] - den_r : rem_sh[DATA_W:0];
      nq_r  <= {nq_r[GAIN_W-2:0], q_bit};
    end
    if (ctrl.mul) begin
      corr_prod_r <= $signed({1'b0, gain}) * $signed(innov_r);
      kp_prod_r   <= gain * var_r;
    end
  end

  assign estimate = prior_r;

endmodule

FILE: rtl/core/skvf_merge.sv
// ----------------------------------------------------------------------------
// skvf_merge: result register
// Gathers the lane estimates into one request and holds it until taken.
// ----------------------------------------------------------------------------
module skvf_merge #(
  parameter int AXES = skvf_pkg::AXES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             load,
  input  logic [AXES*skvf_pkg::DATA_W-1:0] lane_est,
  output logic                             busy,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [AXES*skvf_pkg::DATA_W-1:0] out_tdata
);
  import skvf_pkg::*;

  logic                     valid_r, valid_nxt;
  logic [AXES*DATA_W-1:0]   data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= lane_est;
    end
  end

  // The register can take a new result when empty or being drained.
  assign busy       = valid_r && !out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

FILE: rtl/core/scalar_kalman_velocity_filter.sv
// ----------------------------------------------------------------------------
// scalar_kalman_velocity_filter: three-axis scalar Kalman velocity filter
// Runs one random-walk Kalman filter per axis, side by side in lanes.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_*) carries one velocity request per sample, one
// signed Q16.16 value per axis. The output channel (out_*) returns one
// request of filtered estimates for every input request, in order.
// The configuration port sets the shared measurement noise R (index 0)
// and process noise Q (index 1); other indexes are ignored. Write it only
// while the filter is idle.
// Each axis lane computes the gain P/(P+R) with a restoring divider that
// yields one quotient bit per cycle. The load, the division steps, the
// product, the update and the hand-off to the result register follow in
// that order, and the hand-off raises out_tvalid. The filter takes a new
// request only once the last one has reached the result register.
// A new input is accepted while an earlier result still waits; if the
// receiver stalls, the finished lanes hold until the result register
// frees up. Synchronous reset clears all estimates and variances to zero,
// restores R to 2000.0 and Q to 1.0, and empties the result register.
// ----------------------------------------------------------------------------
module scalar_kalman_velocity_filter #(
  parameter int AXES = skvf_pkg::AXES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Fields, lowest bits first: sample_x, sample_y, sample_z (32 b each).
  input  logic [AXES*skvf_pkg::DATA_W-1:0]     in_tdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // Fields, lowest bits first: estimate_x, estimate_y, estimate_z.
  output logic [AXES*skvf_pkg::DATA_W-1:0]     out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_we,
  input  logic [skvf_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [skvf_pkg::DATA_W-1:0]          cfg_wdata
);
  import skvf_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_HOLD = 3'd4;

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

  logic [2:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r,   cnt_nxt;
  logic [DATA_W-1:0]    meas_noise_r, proc_noise_r;
  lane_ctrl_t           ctrl;
  logic                 in_acc;
  logic                 merge_busy;
  logic                 merge_load;
  logic [AXES*DATA_W-1:0] lane_est;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meas_noise_r <= MEAS_NOISE_RESET;
      proc_noise_r <= PROC_NOISE_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MEAS_NOISE: meas_noise_r <= cfg_wdata;
        REG_PROC_NOISE: proc_noise_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign merge_load = (state_r == ST_HOLD) && !merge_busy;

  // Sequencer shared by all lanes: they run in lock step.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctrl      = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ctrl.load = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        ctrl.step = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        ctrl.mul  = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        ctrl.upd  = 1'b1;
        state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (merge_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  for (genvar i = 0; i < AXES; i++) begin : g_lane
    skvf_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .sample     (in_tdata[i*DATA_W +: DATA_W]),
      .meas_noise (meas_noise_r),
      .proc_noise (proc_noise_r),
      .estimate   (lane_est[i*DATA_W +: DATA_W])
    );
  end

  skvf_merge #(
    .AXES (AXES)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (merge_load),
    .lane_est   (lane_est),
    .busy       (merge_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: rtl/core/skvf_checker.sv
// ----------------------------------------------------------------------------
// skvf_checker: port-level checks for the Kalman velocity filter
// Watches the top-level handshakes over time; bound to the top level.
// ----------------------------------------------------------------------------
module skvf_port_checker #(
  parameter int AXES = skvf_pkg::AXES_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [AXES*skvf_pkg::DATA_W-1:0] out_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // An accepted request keeps the filter busy for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted again too early");

  // A result never appears in the cycle right after an accept.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared too early");

  // Reset leaves the filter ready and the output empty.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("bad state after reset");

endmodule

bind scalar_kalman_velocity_filter skvf_port_checker #(
  .AXES (AXES)
) u_skvf_port_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: verif/skvf_checker.sv
// ----------------------------------------------------------------------------
// skvf_checker: prediction and comparison for the Kalman velocity filter
// Watches the input, result and configuration ports, keeps its own copy of
// the per-axis estimate and variance, and checks every result request
// field by field against the oldest predicted estimate triple.
// ----------------------------------------------------------------------------
module skvf_checker #(
  parameter int AXES = skvf_pkg::AXES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Fields, lowest bits first: sample_x, sample_y, sample_z (32 b each).
  input  logic [AXES*skvf_pkg::DATA_W-1:0]     in_tdata,
  input  logic                                 in_tvalid,
  input  logic                                 in_tready,
  // Fields, lowest bits first: estimate_x, estimate_y, estimate_z.
  input  logic [AXES*skvf_pkg::DATA_W-1:0]     out_tdata,
  input  logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_we,
  input  logic [skvf_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [skvf_pkg::DATA_W-1:0]          cfg_wdata,
  output int                                   mismatches,
  output int                                   awaiting,
  output int                                   checked
);
  import skvf_pkg::*;

  localparam longint EST_MAX  = 64'sd2147483647;
  localparam longint EST_MIN  = -64'sd2147483648;
  localparam longint VAR_CEIL = 64'sd4294967295;

  logic [DATA_W-1:0]        meas_noise;
  logic [DATA_W-1:0]        proc_noise;
  logic signed [DATA_W-1:0] prior_est [AXES];
  logic [DATA_W-1:0]        err_var   [AXES];

  logic [AXES*DATA_W-1:0]   estimate_fifo [$];
  logic [AXES*DATA_W-1:0]   want_word;
  logic [AXES*DATA_W-1:0]   next_word;

  // One scalar filter step on one axis; updates the local state.
  function automatic logic [DATA_W-1:0] filter_one_axis(int a, logic signed [DATA_W-1:0] sample);
    longint p;
    longint den;
    longint gain;
    longint innov;
    longint corr;
    longint est;
    longint kp;
    longint np;
    p     = longint'({32'd0, err_var[a]});
    den   = p + longint'({32'd0, meas_noise});
    gain  = (den != 0) ? ((p <<< FRAC_W) / den) : 0;
    innov = longint'(sample) - longint'(prior_est[a]);
    corr  = (gain * innov) >>> FRAC_W;   // floor toward minus infinity
    est   = longint'(prior_est[a]) + corr;
    if (est > EST_MAX) est = EST_MAX;
    if (est < EST_MIN) est = EST_MIN;
    kp = (gain * p) >>> FRAC_W;
    np = p + longint'({32'd0, proc_noise}) - kp;
    if (np > VAR_CEIL) np = VAR_CEIL;
    err_var[a]   = 32'(np);
    prior_est[a] = 32'(est);
    return 32'(est);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      meas_noise = MEAS_NOISE_RESET;
      proc_noise = PROC_NOISE_RESET;
      for (int a = 0; a < AXES; a++) begin
        prior_est[a] = '0;
        err_var[a]   = '0;
      end
      estimate_fifo.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (estimate_fifo.size() == 0) begin
          $display("%0t: estimate request %h arrived with nothing predicted", $time, out_tdata);
          mismatches++;
        end else begin
          want_word = estimate_fifo.pop_front();
          for (int a = 0; a < AXES; a++) begin
            if (out_tdata[a*DATA_W +: DATA_W] !== want_word[a*DATA_W +: DATA_W]) begin
              $display("%0t: estimate axis %0d mismatch: expected %h, got %h", $time, a,
                       want_word[a*DATA_W +: DATA_W], out_tdata[a*DATA_W +: DATA_W]);
              mismatches++;
            end
          end
          checked++;
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_MEAS_NOISE: meas_noise = cfg_wdata;
          REG_PROC_NOISE: proc_noise = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        for (int a = 0; a < AXES; a++)
          next_word[a*DATA_W +: DATA_W] = filter_one_axis(a, in_tdata[a*DATA_W +: DATA_W]);
        estimate_fifo.push_back(next_word);
      end
    end
    awaiting = estimate_fifo.size();
  end

endmodule

FILE: verif/tb_scalar_kalman_velocity_filter.sv
// ----------------------------------------------------------------------------
// tb_scalar_kalman_velocity_filter: testbench for the Kalman velocity filter
// Drives velocity requests through the filter under several noise settings,
// first a directed set (extreme samples, zero denominator, full gain and
// variance saturation), then randomized requests with random idling on both
// channels. A checker module beside the filter predicts and compares.
// ----------------------------------------------------------------------------
module tb_scalar_kalman_velocity_filter;
  import skvf_pkg::*;

  localparam int AXES = AXES_DEF;
  localparam int W    = AXES * DATA_W;

  // Indexes that map to no register; writes to them must be ignored.
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 2'd3;

  localparam logic [DATA_W-1:0] V_ZERO = 32'h0000_0000;
  localparam logic [DATA_W-1:0] V_LSB  = 32'h0000_0001;
  localparam logic [DATA_W-1:0] V_ONE  = 32'h0001_0000;
  localparam logic [DATA_W-1:0] V_FULL = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] S_MAX  = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] S_MIN  = 32'h8000_0000;

  localparam int IDLE_PCT      = 38;
  localparam int RAND_PHASES   = 5;
  localparam int PHASE_ITEMS   = 160;
  localparam int STEADY_PHASE  = 2;    // phase run with no idling at all
  localparam int PAUSE_PHASE   = 1;    // phase with a full drain midway
  localparam int TAIL_CYCLES   = 50;   // settling time after the final drain
  localparam int RUN_LIMIT     = 2000000;

  logic          clk = 1'b0;
  logic          rst_n;
  logic [W-1:0]  in_tdata;
  logic          in_tvalid;
  logic          in_tready;
  logic [W-1:0]  out_tdata;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic          cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [DATA_W-1:0]     cfg_wdata;

  int mismatches;
  int awaiting;
  int checked;

  bit no_idle = 1'b0;
  int sent_count = 0;
  int settings_count = 0;
  logic [DATA_W-1:0] last_sample [AXES];

  always #2 clk = ~clk;

  scalar_kalman_velocity_filter #(.AXES(AXES)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  skvf_checker #(.AXES(AXES)) estimate_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .awaiting   (awaiting),
    .checked    (checked)
  );

  // The receiver stalls at random on every falling edge, so back-pressure
  // lands at any point of a request's processing, except in the steady
  // phase where it always accepts.
  always @(negedge clk) begin
    out_tready = no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  function automatic bit idle_roll();
    return !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  // Sends one velocity request. The sender may idle first; once valid is
  // raised it holds with stable data until the filter takes it. On return
  // we sit on a falling edge with valid still high, so back-to-back
  // requests never drop valid in between.
  task automatic send_velocity(input logic [DATA_W-1:0] vx, input logic [DATA_W-1:0] vy,
                               input logic [DATA_W-1:0] vz);
    logic [W-1:0] word;
    word = {vz, vy, vx};
    while (idle_roll()) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = word;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    for (int a = 0; a < AXES; a++) last_sample[a] = word[a*DATA_W +: DATA_W];
    sent_count++;
  endtask

  // Stops sending and waits until every predicted estimate has come back.
  // Every request yields exactly one result, so an empty prediction store
  // means the filter is idle.
  task automatic drain_filter();
    in_tvalid = 1'b0;
    while (awaiting != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic set_noise(input logic [DATA_W-1:0] r_val, input logic [DATA_W-1:0] q_val);
    drain_filter();
    write_reg(REG_MEAS_NOISE, r_val);
    write_reg(REG_PROC_NOISE, q_val);
    settings_count++;
  endtask

  // Random sample for one axis: full-range values half the time, with small
  // values, the extremes and small steps from the last sample mixed in so
  // the filter also tracks slowly moving inputs.
  function automatic logic [DATA_W-1:0] random_axis(int a);
    int tmp;
    case ($urandom_range(0, 9))
      5, 6: begin
        tmp = int'($urandom_range(0, 2097152)) - 1048576;
        return tmp;
      end
      7: begin
        case ($urandom_range(0, 3))
          0: return S_MAX;
          1: return S_MIN;
          2: return V_ZERO;
          default: return V_FULL;
        endcase
      end
      8, 9: begin
        tmp = int'($urandom_range(0, 255)) - 128;
        return last_sample[a] + tmp;
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] random_noise();
    case ($urandom_range(0, 6))
      0: return V_ZERO;
      1: return V_LSB;
      2: return V_FULL;
      3: return MEAS_NOISE_RESET;
      4: return V_ONE;
      5: return $urandom_range(0, 16777216);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_MEAS_NOISE;
    cfg_wdata = '0;
    for (int a = 0; a < AXES; a++) last_sample[a] = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed part. First the reset noise settings with extreme samples,
    // so the innovation goes beyond the 32-bit signed range in both directions.
    settings_count = 1;
    send_velocity(V_ZERO, V_ZERO, V_ZERO);
    send_velocity(S_MAX, S_MIN, V_LSB);
    send_velocity(S_MIN, S_MAX, V_FULL);
    send_velocity(S_MAX, S_MAX, S_MAX);
    send_velocity(V_ONE, 32'hFFFF_0000, 32'h8000_0001);

    // R = 0, Q = 0: the first request sees full gain and clears P, after
    // which P + R is zero and the estimate must hold at the prior.
    set_noise(V_ZERO, V_ZERO);
    send_velocity(S_MIN, S_MAX, 32'h0000_3039);
    send_velocity(S_MAX, S_MIN, V_ZERO);
    send_velocity(V_FULL, V_LSB, S_MIN);

    // Q at its maximum with R still zero: zero denominator once more, then
    // P jumps to the ceiling and the gain is a full 1.0.
    set_noise(V_ZERO, V_FULL);
    send_velocity(S_MAX, V_ZERO, S_MIN);
    send_velocity(S_MIN, S_MAX, V_LSB);
    send_velocity(V_ONE, S_MIN, S_MAX);

    // Both variances at the ceiling: the gain drops to one half and the
    // variance update overflows, so P must saturate.
    set_noise(V_FULL, V_FULL);
    send_velocity(S_MIN, S_MAX, V_ZERO);
    send_velocity(S_MAX, S_MIN, V_FULL);
    send_velocity(V_ZERO, V_ZERO, V_ZERO);
    send_velocity(V_LSB, V_FULL, V_ONE);

    // Smallest nonzero noise, plus writes to unused indexes that must not
    // disturb either register.
    set_noise(V_LSB, V_LSB);
    write_reg(REG_SPARE_A, V_ZERO);
    write_reg(REG_SPARE_B, V_FULL);
    send_velocity(S_MAX, V_LSB, S_MIN);
    send_velocity(V_ZERO, S_MIN, S_MAX);
    send_velocity(V_FULL, V_ONE, V_ZERO);

    // Random part, one noise setting per phase.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      set_noise(random_noise(), random_noise());
      if ($urandom_range(0, 1) == 1)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom());
      no_idle = (ph == STEADY_PHASE);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Hold the sender once until the filter has returned everything.
        if (ph == PAUSE_PHASE && i == PHASE_ITEMS / 2)
          drain_filter();
        send_velocity(random_axis(0), random_axis(1), random_axis(2));
      end
      no_idle = 1'b0;
    end

    drain_filter();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Ran %0d velocity requests over %0d noise settings, incl. zero gain, full gain,",
             sent_count, settings_count);
    $display("variance saturation and ignored writes; %0d estimate triples compared.", checked);
    if (mismatches == 0 && awaiting == 0) begin
      $display("scalar_kalman_velocity_filter test passed");
    end else begin
      $display("scalar_kalman_velocity_filter test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #RUN_LIMIT;
    $display("%0t: run limit reached with %0d estimates outstanding", $time, awaiting);
    $display("scalar_kalman_velocity_filter test failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/skvf_pkg.sv
rtl/core/skvf_lane.sv
rtl/core/skvf_merge.sv
rtl/core/scalar_kalman_velocity_filter.sv
rtl/core/skvf_checker.sv
verif/skvf_checker.sv
verif/tb_scalar_kalman_velocity_filter.sv
